/* src/kqsp_pkg.sv */
// kqsp_pkg: request and response types, operation and status codes
// for the shared-pool queue unit; no dependencies
`default_nettype none

package kqsp_pkg;

  localparam int VALUE_W = 32;
  localparam int QSEL_W  = 2;
  localparam int STAT_W  = 2;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;

  // value answered by a dequeue from an empty queue
  localparam logic signed [VALUE_W-1:0] UNDERFLOW_VALUE = -32'sd1;

  typedef struct packed {
    logic                      operation;
    logic [QSEL_W-1:0]         queue_sel;
    logic signed [VALUE_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic [STAT_W-1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

/* src/k_queues_shared_pool_unit.sv */
// k_queues_shared_pool_unit: several fifo queues over one shared slot pool
// depends on kqsp_pkg for the request/response types and codes
`default_nettype none

// Several FIFO queues share one pool of POOL_SLOTS data slots. Each slot holds
// a value and a link to the next slot; unused slots form a free list. A request
// is an enqueue (queue number, value) or a dequeue (queue number) and gets
// exactly one response: status ok, overflow (pool full or bad queue number on
// enqueue) or underflow (queue empty or bad queue number on dequeue, value -1).
// A request is taken when start is high and busy is low. The response shows up
// on out_rsp with out_valid high for one cycle and cannot be held off.
// Sequence: after reset the unit builds the initial free list in the slot
// memory, with busy high. After that a rejected request or an enqueue to an
// empty queue goes from S_IDLE through S_EXEC only; an enqueue onto a
// non-empty queue also passes S_LINK and a successful dequeue also passes
// S_DEQ before busy drops. The extra state is set by the single read port and
// the single write port of the slot memory: a dequeue must read the queue head
// before it can read that slot, and an enqueue must write both the new slot and
// the old tail's link.
module k_queues_shared_pool_unit #(
  parameter int POOL_SLOTS = 16,
  parameter int NUM_QUEUES = 4
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  kqsp_pkg::req_t   in_req,
  output logic             out_valid,
  output kqsp_pkg::rsp_t   out_rsp
);

  import kqsp_pkg::*;

  // pointer holds 0..POOL_SLOTS, POOL_SLOTS meaning null
  localparam int PTR_W  = $clog2(POOL_SLOTS + 1);
  localparam int IDX_W  = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int QIDX_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QCMP_W = ((QIDX_W > QSEL_W) ? QIDX_W : QSEL_W) + 1;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_SLOTS);

  typedef struct packed {
    logic [PTR_W-1:0]          link;
    logic signed [VALUE_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [PTR_W-1:0] tail;
  } qent_t;

  typedef enum logic [2:0] {
    S_INIT,   // building the free list after reset
    S_IDLE,   // waiting for a request
    S_EXEC,   // queue entry and free-head slot read back, decide
    S_LINK,   // chain the old tail to the new slot
    S_DEQ     // head slot read back, unlink and free it
  } state_t;

  // memories: slot pool (value + link) and queue table (head + tail)
  slot_t slot_mem [POOL_SLOTS];
  qent_t qtab_mem [NUM_QUEUES];

  // registers
  state_t                 state_r, state_nxt;
  logic [PTR_W-1:0]       init_cnt_r, init_cnt_nxt;
  logic [PTR_W-1:0]       free_head_r, free_head_nxt;
  logic [NUM_QUEUES-1:0]  qvld_r, qvld_nxt;       // queue entry written since reset
  req_t                   req_r, req_nxt;
  logic [PTR_W-1:0]       tail_r, tail_nxt;       // old tail to be linked
  logic [PTR_W-1:0]       slot_r, slot_nxt;       // slot being enqueued or freed
  logic                   out_valid_r, out_valid_nxt;
  rsp_t                   out_r, out_nxt;
  slot_t                  slot_rd_r;
  qent_t                  qtab_rd_r;

  // memory port controls
  logic                   slot_re;
  logic [IDX_W-1:0]       slot_ra;
  logic                   slot_we_link;
  logic                   slot_we_val;
  logic [IDX_W-1:0]       slot_wa;
  slot_t                  slot_wd;
  logic                   qtab_re;
  logic [QIDX_W-1:0]      qtab_ra;
  logic                   qtab_we;
  logic [QIDX_W-1:0]      qtab_wa;
  qent_t                  qtab_wd;

  // decode of the held request
  logic                   accept;
  logic [QIDX_W-1:0]      q_idx;
  logic                   q_ok;
  logic [PTR_W-1:0]       head_eff;
  logic                   head_is_slot;
  logic                   tail_is_slot;
  logic                   pool_full;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_r;

  assign q_idx        = QIDX_W'(req_r.queue_sel);
  assign q_ok         = QCMP_W'(req_r.queue_sel) < QCMP_W'(NUM_QUEUES);
  // a queue entry never written reads as an empty queue
  assign head_eff     = qvld_r[q_idx] ? qtab_rd_r.head : NULL_PTR;
  assign head_is_slot = head_eff < NULL_PTR;
  assign tail_is_slot = qtab_rd_r.tail < NULL_PTR;
  assign pool_full    = !(free_head_r < NULL_PTR);

  always_comb begin
    state_nxt     = state_r;
    init_cnt_nxt  = init_cnt_r;
    free_head_nxt = free_head_r;
    qvld_nxt      = qvld_r;
    req_nxt       = req_r;
    tail_nxt      = tail_r;
    slot_nxt      = slot_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;

    slot_re      = 1'b0;
    slot_ra      = free_head_r[IDX_W-1:0];
    slot_we_link = 1'b0;
    slot_we_val  = 1'b0;
    slot_wa      = slot_r[IDX_W-1:0];
    slot_wd      = '{link: NULL_PTR, value: req_r.item_value};
    qtab_re      = 1'b0;
    qtab_ra      = QIDX_W'(in_req.queue_sel);
    qtab_we      = 1'b0;
    qtab_wa      = q_idx;
    qtab_wd      = qtab_rd_r;

    case (state_r)
      S_INIT: begin
        // slot i links to i+1; the last one links to null
        slot_we_link = 1'b1;
        slot_wa      = init_cnt_r[IDX_W-1:0];
        slot_wd.link = init_cnt_r + PTR_W'(1);
        init_cnt_nxt = init_cnt_r + PTR_W'(1);
        if (init_cnt_r == PTR_W'(POOL_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          slot_re   = 1'b1;             // free-head slot, for its link
          qtab_re   = 1'b1;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (req_r.operation == OP_ENQ) begin
          if (!q_ok || pool_full) begin
            out_nxt       = '{out_value: '0, status: ST_OVERFLOW};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            // take the free-list head and fill it
            slot_we_link  = 1'b1;
            slot_we_val   = 1'b1;
            slot_wa       = free_head_r[IDX_W-1:0];
            slot_wd       = '{link: NULL_PTR, value: req_r.item_value};
            free_head_nxt = slot_rd_r.link;
            qtab_we       = 1'b1;
            qtab_wd.head  = head_is_slot ? qtab_rd_r.head : free_head_r;
            qtab_wd.tail  = free_head_r;
            qvld_nxt[q_idx] = 1'b1;
            if (head_is_slot && tail_is_slot) begin
              tail_nxt  = qtab_rd_r.tail;
              slot_nxt  = free_head_r;
              state_nxt = S_LINK;
            end else begin
              out_nxt       = '{out_value: '0, status: ST_OK};
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
            end
          end
        end else begin
          if (!q_ok || !head_is_slot) begin
            out_nxt       = '{out_value: UNDERFLOW_VALUE, status: ST_UNDERFLOW};
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end else begin
            // fetch the head slot
            slot_re   = 1'b1;
            slot_ra   = head_eff[IDX_W-1:0];
            slot_nxt  = head_eff;
            state_nxt = S_DEQ;
          end
        end
      end

      S_LINK: begin
        slot_we_link  = 1'b1;
        slot_wa       = tail_r[IDX_W-1:0];
        slot_wd.link  = slot_r;
        out_nxt       = '{out_value: '0, status: ST_OK};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      S_DEQ: begin
        // advance the queue head, push the slot onto the free list
        qtab_we       = 1'b1;
        qtab_wd.head  = slot_rd_r.link;
        qtab_wd.tail  = qtab_rd_r.tail;
        slot_we_link  = 1'b1;
        slot_wa       = slot_r[IDX_W-1:0];
        slot_wd.link  = free_head_r;
        free_head_nxt = slot_r;
        out_nxt       = '{out_value: slot_rd_r.value, status: ST_OK};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      init_cnt_r  <= '0;
      free_head_r <= '0;
      qvld_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_cnt_r  <= init_cnt_nxt;
      free_head_r <= free_head_nxt;
      qvld_r      <= qvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r  <= req_nxt;
    tail_r <= tail_nxt;
    slot_r <= slot_nxt;
    out_r  <= out_nxt;
  end

  // slot memory: one read port, one write port with separate link/value enables
  always_ff @(posedge clk) begin
    if (slot_we_link) begin
      slot_mem[slot_wa].link <= slot_wd.link;
    end
    if (slot_we_val) begin
      slot_mem[slot_wa].value <= slot_wd.value;
    end
    if (slot_re) begin
      slot_rd_r <= slot_mem[slot_ra];
    end
  end

  // queue table memory
  always_ff @(posedge clk) begin
    if (qtab_we) begin
      qtab_mem[qtab_wa] <= qtab_wd;
    end
    if (qtab_re) begin
      qtab_rd_r <= qtab_mem[qtab_ra];
    end
  end

  // assertions
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_EXEC)
    else $error("accepted request did not enter decode");

  a_free_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    free_head_r <= NULL_PTR)
    else $error("free-list head beyond null");

  a_resp_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) == S_EXEC || $past(state_r) == S_LINK ||
                     $past(state_r) == S_DEQ))
    else $error("response without a request in flight");

  a_resp_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("response while still busy");

  a_underflow_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == ST_UNDERFLOW) |-> out_r.out_value == UNDERFLOW_VALUE)
    else $error("underflow response with wrong value");

endmodule

`default_nettype wire
